@@ hw/rtl/gcode_word_tokenizer_top_macros.svh @@
// Assertion macros shared by the tokenizer's checking code.
`ifndef GCODE_WORD_TOKENIZER_TOP_MACROS_SVH
`define GCODE_WORD_TOKENIZER_TOP_MACROS_SVH

// Checks that a condition implies a consequence on the same clock edge.
`define GWT_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence on the next clock edge.
`define GWT_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/gwt_pkg.sv @@
// Types, character codes and constants of the G-code word tokenizer.
`default_nettype none

package gwt_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
  } gwt_in_t;

  typedef struct packed {
    logic              word_valid;
    logic [6:0]        word_letter;
    logic signed [31:0] int_value;
    logic signed [47:0] fixed_value;
    logic              is_command;
    logic              line_end;
  } gwt_res_t;

  typedef enum logic [1:0] {
    MODE_BETWEEN,
    MODE_BODY,
    MODE_SKIP,
    MODE_COMMENT
  } scan_mode_t;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_9     = 8'd57;
  localparam logic [7:0] CH_SEMI  = 8'd59;
  localparam logic [7:0] CH_UA    = 8'd65;
  localparam logic [7:0] CH_UN    = 8'd78;
  localparam logic [7:0] CH_UZ    = 8'd90;
  localparam logic [7:0] CH_LA    = 8'd97;
  localparam logic [7:0] CH_LZ    = 8'd122;
  localparam logic [7:0] CASE_GAP = 8'd32;

  localparam logic [31:0] INT_CAP = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [47:0] FIX_CAP = 48'h8000_0000_0000;
  localparam logic [47:0] FIX_MAX = 48'h7FFF_FFFF_FFFF;

  // Powers of ten for the fraction scale; large enough for six digits.
  function automatic logic [19:0] pow10(input logic [2:0] k);
    logic [19:0] p;
    unique case (k)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      3'd6:    p = 20'd1000000;
      default: p = 20'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gwt_in_stage.sv @@
// Input register that holds one incoming beat until the scanner takes it.
`default_nettype none

module gwt_in_stage
  import gwt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    src_valid,
  output logic         src_stall,
  input  wire gwt_in_t src_data,
  input  wire logic    out_free,
  output logic         take,
  output gwt_in_t      item
);

  logic full;
  logic accept;

  assign take      = full && out_free;
  assign src_stall = full && !out_free;
  assign accept    = src_valid && !src_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= src_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gwt_scan.sv @@
// Word scanner: line state, number accumulation and result formation.
`default_nettype none

module gwt_scan
  import gwt_pkg::*;
#(
  parameter int FRAC_DIGITS = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    take,
  input  wire gwt_in_t item,
  output logic         res_fire,
  output gwt_res_t     res
);

  localparam logic [2:0]  FRAC    = 3'(FRAC_DIGITS);
  localparam logic [19:0] POW_INT = pow10(FRAC);

  scan_mode_t  mode, mode_next;
  logic [4:0]  held_letter, held_letter_next;
  logic        body_seen, body_seen_next;
  logic        lead_done, lead_done_next;
  logic        negative, negative_next;
  logic [31:0] int_mag, int_mag_next;
  logic        int_stopped, int_stopped_next;
  logic [47:0] fix_mag, fix_mag_next;
  logic        point_seen, point_seen_next;
  logic [2:0]  frac_count, frac_count_next;
  logic        fix_stopped, fix_stopped_next;
  logic        cmd_taken, cmd_taken_next;

  logic [7:0]  c;
  logic [7:0]  up;
  logic        letter_ok;
  logic        is_digit;
  logic [3:0]  digit_val;
  logic [2:0]  count_inc;
  logic [35:0] int_wide;
  logic [31:0] int_acc;
  logic [23:0] int_term;
  logic [23:0] frac_term;
  logic [51:0] fix_int_wide;
  logic [51:0] fix_frac_wide;
  logic [47:0] fix_int_acc;
  logic [47:0] fix_frac_acc;
  logic        clear_word;
  logic        load_letter;
  logic        body_byte;
  logic        word_out;
  logic [31:0] int_out;
  logic [47:0] fix_out;

  assign c         = item.char_code;
  assign up        = (c >= CH_LA && c <= CH_LZ) ? c - CASE_GAP : c;
  assign letter_ok = up >= CH_UA && up <= CH_UZ && up != CH_UN;
  assign is_digit  = c >= CH_0 && c <= CH_9;
  assign digit_val = is_digit ? c[3:0] : 4'd0;
  assign count_inc = frac_count + 3'd1;

  // Multiply by ten as two shifts, then add the new digit.
  assign int_wide = ({4'b0, int_mag} << 3) + ({4'b0, int_mag} << 1) + 36'(digit_val);
  assign int_acc  = (int_wide > 36'(INT_CAP)) ? INT_CAP : int_wide[31:0];

  assign int_term     = 24'(digit_val) * 24'(POW_INT);
  assign frac_term    = 24'(digit_val) * 24'(pow10(FRAC - count_inc));
  assign fix_int_wide = ({4'b0, fix_mag} << 3) + ({4'b0, fix_mag} << 1) + 52'(int_term);
  assign fix_frac_wide = {4'b0, fix_mag} + 52'(frac_term);
  assign fix_int_acc  = (fix_int_wide > 52'(FIX_CAP)) ? FIX_CAP : fix_int_wide[47:0];
  assign fix_frac_acc = (fix_frac_wide > 52'(FIX_CAP)) ? FIX_CAP : fix_frac_wide[47:0];

  always_comb begin
    clear_word  = 1'b0;
    load_letter = 1'b0;
    body_byte   = 1'b0;
    mode_next      = mode;
    cmd_taken_next = cmd_taken;
    if (take) begin
      if (item.cmd == CMD_EOL) begin
        mode_next      = MODE_BETWEEN;
        cmd_taken_next = 1'b0;
        clear_word     = 1'b1;
      end else begin
        unique case (mode)
          MODE_BETWEEN: begin
            if (c == CH_SPACE) begin
              mode_next = MODE_BETWEEN;
            end else if (c == CH_SEMI) begin
              mode_next = MODE_COMMENT;
            end else if (!letter_ok) begin
              mode_next = MODE_SKIP;
            end else begin
              clear_word  = 1'b1;
              load_letter = 1'b1;
              mode_next   = MODE_BODY;
            end
          end
          MODE_BODY: begin
            if (c == CH_SPACE) begin
              cmd_taken_next = 1'b1;
              clear_word     = 1'b1;
              mode_next      = MODE_BETWEEN;
            end else begin
              body_byte = 1'b1;
            end
          end
          MODE_SKIP: begin
            if (c == CH_SPACE) begin
              mode_next = MODE_BETWEEN;
            end
          end
          MODE_COMMENT: begin
            mode_next = MODE_COMMENT;
          end
          default: begin
            mode_next = MODE_BETWEEN;
          end
        endcase
      end
    end
  end

  always_comb begin
    held_letter_next = held_letter;
    body_seen_next   = body_seen;
    lead_done_next   = lead_done;
    negative_next    = negative;
    int_mag_next     = int_mag;
    int_stopped_next = int_stopped;
    fix_mag_next     = fix_mag;
    point_seen_next  = point_seen;
    frac_count_next  = frac_count;
    fix_stopped_next = fix_stopped;
    if (clear_word) begin
      held_letter_next = 5'd0;
      body_seen_next   = 1'b0;
      lead_done_next   = 1'b0;
      negative_next    = 1'b0;
      int_mag_next     = 32'd0;
      int_stopped_next = 1'b0;
      fix_mag_next     = 48'd0;
      point_seen_next  = 1'b0;
      frac_count_next  = 3'd0;
      fix_stopped_next = 1'b0;
    end
    if (load_letter) begin
      held_letter_next = 5'(up - CH_UA);
    end
    if (body_byte) begin
      body_seen_next = 1'b1;
      priority if (!lead_done && c >= CH_TAB && c <= CH_CR) begin
        lead_done_next = 1'b0;
      end else if (!lead_done && (c == CH_PLUS || c == CH_MINUS)) begin
        lead_done_next = 1'b1;
        negative_next  = (c == CH_MINUS);
      end else begin
        lead_done_next = 1'b1;
        if (!int_stopped) begin
          if (is_digit) begin
            int_mag_next = int_acc;
          end else begin
            int_stopped_next = 1'b1;
          end
        end
        if (!fix_stopped) begin
          priority if (is_digit && !point_seen) begin
            fix_mag_next = fix_int_acc;
          end else if (is_digit) begin
            // Digits beyond the scale are dropped, which truncates the value.
            if (frac_count < FRAC) begin
              frac_count_next = count_inc;
              fix_mag_next    = fix_frac_acc;
            end
          end else if (c == CH_POINT && !point_seen) begin
            point_seen_next = 1'b1;
          end else begin
            fix_stopped_next = 1'b1;
          end
        end
      end
    end
  end

  assign res_fire = take && ((item.cmd == CMD_EOL) ||
                             (mode == MODE_BODY && c == CH_SPACE));
  assign word_out = (mode == MODE_BODY) && ((item.cmd == CMD_CHAR) || body_seen);
  assign int_out  = negative ? (32'd0 - int_mag) :
                    ((int_mag > INT_MAX) ? INT_MAX : int_mag);
  assign fix_out  = negative ? (48'd0 - fix_mag) :
                    ((fix_mag > FIX_MAX) ? FIX_MAX : fix_mag);

  always_comb begin
    res            = '0;
    res.line_end   = item.cmd;
    if (word_out) begin
      res.word_valid  = 1'b1;
      res.word_letter = CH_UA[6:0] + 7'(held_letter);
      res.int_value   = $signed(int_out);
      res.fixed_value = $signed(fix_out);
      res.is_command  = !cmd_taken;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_BETWEEN;
      held_letter <= 5'd0;
      body_seen   <= 1'b0;
      lead_done   <= 1'b0;
      negative    <= 1'b0;
      int_mag     <= 32'd0;
      int_stopped <= 1'b0;
      fix_mag     <= 48'd0;
      point_seen  <= 1'b0;
      frac_count  <= 3'd0;
      fix_stopped <= 1'b0;
      cmd_taken   <= 1'b0;
    end else begin
      mode        <= mode_next;
      held_letter <= held_letter_next;
      body_seen   <= body_seen_next;
      lead_done   <= lead_done_next;
      negative    <= negative_next;
      int_mag     <= int_mag_next;
      int_stopped <= int_stopped_next;
      fix_mag     <= fix_mag_next;
      point_seen  <= point_seen_next;
      frac_count  <= frac_count_next;
      fix_stopped <= fix_stopped_next;
      cmd_taken   <= cmd_taken_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gwt_out_stage.sv @@
// Result register that holds one result beat until the consumer takes it.
`default_nettype none

module gwt_out_stage
  import gwt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     res_fire,
  input  wire gwt_res_t res,
  output logic          out_free,
  output logic          res_valid,
  input  wire logic     res_stall,
  output gwt_res_t      res_data
);

  assign out_free = !(res_valid && res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      res_data <= res;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gcode_word_tokenizer_top.sv @@
// Top level of the G-code word tokenizer.
`default_nettype none

// Takes one beat per cycle on the source channel: a line character or an
// end-of-line marker. Each beat passes an input register and is scanned, once the
// scanner takes it, by the word state and the multiply-by-ten accumulators.
// A result, if the beat causes one, lands in the result register at the end of
// the cycle in which its beat is scanned.
// The sustained rate is one beat per cycle; while a result waits under stall,
// the scanner holds and the source is stalled once the input register fills.
// A space ends a word with line_end 0; every end-of-line beat gives exactly
// one result, a word if a letter had a body, otherwise a bare end marker.
module gcode_word_tokenizer_top
  import gwt_pkg::*;
#(
  parameter int FRAC_DIGITS = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    src_valid,
  output logic         src_stall,
  input  wire gwt_in_t src_data,
  output logic         res_valid,
  input  wire logic    res_stall,
  output gwt_res_t     res_data
);

  `include "gcode_word_tokenizer_top_macros.svh"

  logic     out_free;
  logic     take;
  gwt_in_t  item;
  logic     res_fire;
  gwt_res_t res;

  gwt_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .out_free  (out_free),
    .take      (take),
    .item      (item)
  );

  gwt_scan #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .res_fire (res_fire),
    .res      (res)
  );

  gwt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_fire  (res_fire),
    .res       (res),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  `GWT_ASSERT_SAME(a_bare_is_line_end, res_valid && !res_data.word_valid,
    res_data.line_end, "bare result without line end")

  `GWT_ASSERT_SAME(a_letter_range, res_valid && res_data.word_valid,
    res_data.word_letter >= CH_UA[6:0] && res_data.word_letter <= CH_UZ[6:0],
    "word letter outside A to Z")

  `GWT_ASSERT_SAME(a_sign_agrees, res_valid && res_data.word_valid && res_data.int_value[31],
    res_data.fixed_value[47], "negative integer with nonnegative fixed value")

  `GWT_ASSERT_NEXT(a_fire_loads, res_fire, res_valid, "result fired but not held")

endmodule

`default_nettype wire

@@ tb/sv/tb_gcode_word_tokenizer_top.sv @@
// Self-checking testbench for the G-code word tokenizer with a line predictor.
module tb_gcode_word_tokenizer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gwt_pkg::*;

  localparam int FRAC_DIGITS = 4;
  localparam int RUN_BEATS = 1700;
  localparam int HOLD_CYCLES = 300;
  localparam logic [7:0] CH_STAR = 8'h2A;

  // Predicts the words of each line and checks the results as they arrive.
  class word_scoreboard;
    int unsigned errors;
    gwt_res_t expected_words[$];
    scan_mode_t mode;
    logic [4:0] letter;
    logic [31:0] int_mag;
    logic [47:0] fixed_mag;
    int unsigned frac_count;
    bit body_seen, lead_done, negative, int_stopped, point_seen, fixed_stopped;
    bit command_taken;

    function new();
      errors = 0;
      mode = MODE_BETWEEN;
      command_taken = 1'b0;
      clear_word();
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void clear_word();
      letter = '0;
      int_mag = '0;
      fixed_mag = '0;
      frac_count = 0;
      body_seen = 1'b0;
      lead_done = 1'b0;
      negative = 1'b0;
      int_stopped = 1'b0;
      point_seen = 1'b0;
      fixed_stopped = 1'b0;
    endfunction

    function logic [63:0] clip(logic [63:0] v, logic [63:0] cap);
      return (v > cap) ? cap : v;
    endfunction

    function logic [63:0] ten_pow(int unsigned k);
      logic [63:0] p;
      p = 64'd1;
      repeat (k) p = p * 10;
      return p;
    endfunction

    function void take_body_byte(logic [7:0] c);
      bit digit;
      logic [63:0] d;
      digit = (c >= CH_0) && (c <= CH_9);
      d = digit ? 64'(c - CH_0) : 64'd0;
      body_seen = 1'b1;
      if (!lead_done) begin
        if (c >= CH_TAB && c <= CH_CR) return;
        lead_done = 1'b1;
        if (c == CH_PLUS || c == CH_MINUS) begin
          negative = (c == CH_MINUS);
          return;
        end
      end
      if (!int_stopped) begin
        if (digit) int_mag = 32'(clip(64'(int_mag) * 10 + d, 64'(INT_CAP)));
        else int_stopped = 1'b1;
      end
      if (!fixed_stopped) begin
        if (digit) begin
          if (!point_seen) begin
            fixed_mag = 48'(clip(64'(fixed_mag) * 10 + d * ten_pow(FRAC_DIGITS),
                                 64'(FIX_CAP)));
          end else if (frac_count < FRAC_DIGITS) begin
            // Fraction digits beyond the scale are dropped, which truncates.
            frac_count++;
            fixed_mag = 48'(clip(64'(fixed_mag) + d * ten_pow(FRAC_DIGITS - frac_count),
                                 64'(FIX_CAP)));
          end
        end else if (c == CH_POINT && !point_seen) begin
          point_seen = 1'b1;
        end else begin
          fixed_stopped = 1'b1;
        end
      end
    endfunction

    function gwt_res_t word_result(bit at_end);
      gwt_res_t r;
      logic [31:0] im;
      logic [47:0] fm;
      r = '0;
      r.word_valid = 1'b1;
      r.word_letter = 7'(CH_UA + 8'(letter));
      if (negative) begin
        im = (int_mag > INT_CAP) ? INT_CAP : int_mag;
        fm = (fixed_mag > FIX_CAP) ? FIX_CAP : fixed_mag;
        r.int_value = -im;
        r.fixed_value = -fm;
      end else begin
        r.int_value = (int_mag > INT_MAX) ? INT_MAX : int_mag;
        r.fixed_value = (fixed_mag > FIX_MAX) ? FIX_MAX : fixed_mag;
      end
      r.is_command = !command_taken;
      r.line_end = at_end;
      command_taken = 1'b1;
      return r;
    endfunction

    function void predict_beat(gwt_in_t b);
      logic [7:0] c;
      gwt_res_t marker;
      c = b.char_code;
      if (b.cmd == CMD_EOL) begin
        if (mode == MODE_BODY && body_seen) begin
          expected_words.push_back(word_result(1'b1));
        end else begin
          marker = '0;
          marker.line_end = 1'b1;
          expected_words.push_back(marker);
        end
        mode = MODE_BETWEEN;
        command_taken = 1'b0;
        clear_word();
        return;
      end
      case (mode)
        MODE_BETWEEN: begin
          if (c == CH_SEMI) begin
            mode = MODE_COMMENT;
          end else if (c != CH_SPACE) begin
            if (c >= CH_LA && c <= CH_LZ) c = c - CASE_GAP;
            if (c < CH_UA || c > CH_UZ || c == CH_UN) begin
              mode = MODE_SKIP;
            end else begin
              clear_word();
              letter = 5'(c - CH_UA);
              mode = MODE_BODY;
            end
          end
        end
        MODE_BODY: begin
          if (c == CH_SPACE) begin
            expected_words.push_back(word_result(1'b0));
            clear_word();
            mode = MODE_BETWEEN;
          end else begin
            take_body_byte(c);
          end
        end
        MODE_SKIP: begin
          if (c == CH_SPACE) mode = MODE_BETWEEN;
        end
        default: begin
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task compare(string field, longint got, longint want);
      if (got != want) report($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task check_result(gwt_res_t got);
      gwt_res_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("result with nothing expected, letter %0d line_end %0d",
                         got.word_letter, got.line_end));
        return;
      end
      want = expected_words.pop_front();
      if ($isunknown(got)) report("result has unknown bits");
      compare("word_valid", got.word_valid, want.word_valid);
      compare("word_letter", got.word_letter, want.word_letter);
      compare("int_value", got.int_value, want.int_value);
      compare("fixed_value", got.fixed_value, want.fixed_value);
      compare("is_command", got.is_command, want.is_command);
      compare("line_end", got.line_end, want.line_end);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  gwt_in_t src_data = '0;
  logic res_stall = 1'b0;
  logic src_stall;
  logic res_valid;
  gwt_res_t res_data;

  word_scoreboard token_check;
  gwt_in_t line_beats[$];
  int unsigned beats_sent = 0;
  bit src_idling = 1'b1;
  bit sink_idling = 1'b1;
  bit hold_req = 1'b0;

  gcode_word_tokenizer_top #(.FRAC_DIGITS(FRAC_DIGITS)) dut (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_data(src_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (src_valid && !src_stall) token_check.predict_beat(src_data);
      if (res_valid && !res_stall) token_check.check_result(res_data);
    end
  end

  function automatic void put_char(logic [7:0] c);
    gwt_in_t b;
    b.cmd = CMD_CHAR;
    b.char_code = c;
    line_beats.push_back(b);
  endfunction

  // The byte that rides along with an end of line is ignored, so it is random.
  function automatic void put_eol();
    gwt_in_t b;
    b.cmd = CMD_EOL;
    b.char_code = 8'($urandom_range(0, 255));
    line_beats.push_back(b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  function automatic void put_digits(int unsigned n);
    repeat (n) put_char(8'(CH_0 + $urandom_range(0, 9)));
  endfunction

  function automatic void put_letter();
    logic [7:0] c;
    c = 8'(CH_UA + $urandom_range(0, 25));
    if ($urandom_range(0, 1)) c = c + CASE_GAP;
    put_char(c);
  endfunction

  function automatic void put_number();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 2)) put_char(8'($urandom_range(CH_TAB, CH_CR)));
    end
    case ($urandom_range(0, 5))
      0, 1: put_char(CH_MINUS);
      2: put_char(CH_PLUS);
      default: begin
      end
    endcase
    // Now and then a long run of digits, which at its longer lengths saturates both values.
    put_digits(($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 5));
    if ($urandom_range(0, 1)) begin
      put_char(CH_POINT);
      put_digits($urandom_range(0, 7));
    end
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: put_char(CH_POINT);
        1: put_char(CH_MINUS);
        2: put_char("e");
        default: put_char(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  function automatic void make_line();
    int unsigned word_count;
    word_count = $urandom_range(0, 5);
    for (int w = 0; w < word_count; w++) begin
      if (w > 0) repeat ($urandom_range(1, 2)) put_char(CH_SPACE);
      case ($urandom_range(0, 19))
        0: repeat ($urandom_range(1, 4)) put_char(8'($urandom_range(0, 255)));
        1: begin
          put_char(CH_SEMI);
          repeat ($urandom_range(0, 6)) put_char(8'($urandom_range(0, 255)));
        end
        2: begin
          put_char($urandom_range(0, 1) ? CH_UN : CH_STAR);
          put_number();
        end
        3: put_letter();
        default: begin
          put_letter();
          put_number();
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) put_char(CH_SPACE);
    put_eol();
  endfunction

  // A broken line: random bytes with a stray end of line now and then.
  function automatic void make_noise_line();
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 7) == 0) put_eol();
      else put_char(8'($urandom_range(0, 255)));
    end
    put_eol();
  endfunction

  task automatic send_line();
    while (line_beats.size() != 0) begin
      if (src_idling && $urandom_range(0, 5) == 0) begin
        src_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      src_valid <= 1'b1;
      src_data <= line_beats.pop_front();
      do @(posedge clk); while (src_stall);
      beats_sent++;
    end
  endtask

  task automatic wait_drained();
    src_valid <= 1'b0;
    do @(posedge clk); while (token_check.pending() != 0);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        res_stall <= 1'b0;
      end else if (sink_idling && $urandom_range(0, 4) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  initial begin
    bit hold_done;
    bit drain_done;
    hold_done = 1'b0;
    drain_done = 1'b0;
    token_check = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Lower case, sign, point, extra fraction digits, and a trailing bare letter.
    put_text("g-1.23456 x");
    put_eol();
    // Skipped N word, empty body ended by a space, then a comment.
    put_text("N1 Y ;G1");
    put_eol();
    put_eol();
    // Byte extremes: a skipped word of 0xFF and a NUL body ended by the line end.
    put_char(8'hFF);
    put_text(" M");
    put_char(8'h00);
    put_eol();
    send_line();

    while (beats_sent < RUN_BEATS) begin
      if (!hold_done && beats_sent >= 600) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && beats_sent >= 1000) begin
        wait_drained();
        drain_done = 1'b1;
      end
      if (beats_sent >= 1450) begin
        src_idling = 1'b0;
        sink_idling = 1'b0;
      end
      if ($urandom_range(0, 11) == 0) make_noise_line();
      else make_line();
      send_line();
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (token_check.errors == 0) begin
      $display("gcode_word_tokenizer_top: match");
    end else begin
      $display("gcode_word_tokenizer_top: mismatch");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("gcode_word_tokenizer_top: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/gwt_pkg.sv
hw/rtl/gwt_in_stage.sv
hw/rtl/gwt_scan.sv
hw/rtl/gwt_out_stage.sv
hw/rtl/gcode_word_tokenizer_top.sv
tb/sv/tb_gcode_word_tokenizer_top.sv
